[hw/rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the table engine.
// Depends on nothing; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

[hw/rtl/aste_pkg.sv]
// Package of the table engine: codes, state encoding and the
// command/status structs between controller and datapath. No dependencies.
package aste_pkg;

  localparam int unsigned CAPACITY_DEF = 64;
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned POS_W    = 6;
  localparam int unsigned COUNT_W  = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 2'd0,
    CMD_SEARCH = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_SORT   = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_MISS  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_SCAN,
    S_SHIFT,
    S_SORT_KEY,
    S_SORT_LOAD,
    S_SORT_CMP,
    S_PUBLISH
  } state_e;

  typedef enum logic [2:0] {
    RD_ZERO,
    RD_PTR,
    RD_PTR1,
    RD_PTR2,
    RD_PTRM1,
    RD_JM2
  } rd_sel_e;

  typedef enum logic [1:0] {
    WR_VALUE,
    WR_RDATA,
    WR_KEY
  } wr_sel_e;

  typedef enum logic [1:0] {
    WA_COUNT,
    WA_PTR,
    WA_J
  } wa_sel_e;

  typedef enum logic [1:0] {
    PTR_HOLD,
    PTR_ZERO,
    PTR_ONE,
    PTR_INC
  } ptr_op_e;

  typedef struct packed {
    logic    latch_in;
    logic    mem_we;
    wr_sel_e wr_sel;
    wa_sel_e wa_sel;
    rd_sel_e rd_sel;
    ptr_op_e ptr_op;
    logic    j_load;
    logic    j_dec;
    logic    key_load;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    res_load;
    status_e res_status;
    logic    res_found;
    logic    out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic hit;
    logic last;
    logic sort_done;
    logic j_zero;
    logic gt;
  } dp_stat_t;

endpackage

[hw/rtl/aste_dpath.sv]
// Datapath of the table engine: slot memory, fill count, walk pointers,
// sort key and result/output registers. Depends on aste_pkg.
module aste_dpath #(
  parameter int unsigned CAPACITY = aste_pkg::CAPACITY_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  aste_pkg::ctl_cmd_t                cmd_i,
  output aste_pkg::dp_stat_t                stat_o,
  input  logic signed [aste_pkg::VALUE_W-1:0] value_i,
  output logic [aste_pkg::STATUS_W-1:0]     status_o,
  output logic                              found_o,
  output logic [aste_pkg::POS_W-1:0]        position_o,
  output logic [aste_pkg::COUNT_W-1:0]      count_o,
  output logic                              is_empty_o,
  output logic                              is_full_o
);

  localparam int unsigned AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW  = $clog2(CAPACITY + 1);
  localparam int unsigned PXW = AW + aste_pkg::POS_W;
  localparam int unsigned CXW = CW + aste_pkg::COUNT_W;
  localparam int unsigned VW  = aste_pkg::VALUE_W;

  logic signed [VW-1:0] mem [CAPACITY];

  logic signed [VW-1:0] value_q, key_q, rdata_q, wr_data;
  logic [AW-1:0]        rd_addr, wr_addr, ptr_a;
  logic [AW-1:0]        j_q, j_d;
  logic [CW-1:0]        ptr_q, ptr_d;
  logic [CW-1:0]        count_q, count_d;
  aste_pkg::status_e    res_status_q;
  logic                 res_found_q;
  logic [AW-1:0]        res_pos_q;
  aste_pkg::status_e    out_status_q;
  logic                 out_found_q;
  logic [AW-1:0]        out_pos_q;
  logic [CW-1:0]        out_count_q;
  logic [PXW-1:0]       pos_x;
  logic [CXW-1:0]       cnt_x;

  assign ptr_a = ptr_q[AW-1:0];

  always_comb begin
    case (cmd_i.rd_sel)
      aste_pkg::RD_ZERO:  rd_addr = '0;
      aste_pkg::RD_PTR:   rd_addr = ptr_a;
      aste_pkg::RD_PTR1:  rd_addr = ptr_a + AW'(1);
      aste_pkg::RD_PTR2:  rd_addr = ptr_a + AW'(2);
      aste_pkg::RD_PTRM1: rd_addr = ptr_a - AW'(1);
      aste_pkg::RD_JM2:   rd_addr = j_q - AW'(2);
      default:            rd_addr = '0;
    endcase
  end

  always_comb begin
    case (cmd_i.wa_sel)
      aste_pkg::WA_COUNT: wr_addr = count_q[AW-1:0];
      aste_pkg::WA_PTR:   wr_addr = ptr_a;
      aste_pkg::WA_J:     wr_addr = j_q;
      default:            wr_addr = '0;
    endcase
  end

  always_comb begin
    case (cmd_i.wr_sel)
      aste_pkg::WR_VALUE: wr_data = value_q;
      aste_pkg::WR_RDATA: wr_data = rdata_q;
      aste_pkg::WR_KEY:   wr_data = key_q;
      default:            wr_data = value_q;
    endcase
  end

  // Slot memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_q <= mem[rd_addr];
  end

  always_comb begin
    case (cmd_i.ptr_op)
      aste_pkg::PTR_HOLD: ptr_d = ptr_q;
      aste_pkg::PTR_ZERO: ptr_d = '0;
      aste_pkg::PTR_ONE:  ptr_d = CW'(1);
      aste_pkg::PTR_INC:  ptr_d = ptr_q + CW'(1);
      default:            ptr_d = ptr_q;
    endcase
  end

  always_comb begin
    j_d = j_q;
    if (cmd_i.j_load) begin
      j_d = ptr_a;
    end else if (cmd_i.j_dec) begin
      j_d = j_q - AW'(1);
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.cnt_inc) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.cnt_dec) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    j_q   <= j_d;
    if (cmd_i.latch_in) begin
      value_q <= value_i;
    end
    if (cmd_i.key_load) begin
      key_q <= rdata_q;
    end
    if (cmd_i.res_load) begin
      res_status_q <= cmd_i.res_status;
      res_found_q  <= cmd_i.res_found;
      res_pos_q    <= cmd_i.res_found ? ptr_a : '0;
    end
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_found_q  <= res_found_q;
      out_pos_q    <= res_pos_q;
      out_count_q  <= count_q;
    end
  end

  assign stat_o.full      = (count_q == CW'(CAPACITY));
  assign stat_o.empty     = (count_q == '0);
  assign stat_o.hit       = (rdata_q == value_q);
  assign stat_o.last      = (ptr_q == count_q - CW'(1));
  assign stat_o.sort_done = (ptr_q == count_q);
  assign stat_o.j_zero    = (j_q == '0);
  assign stat_o.gt        = (rdata_q > key_q);

  // Position and count are masked to the field widths for large tables.
  assign pos_x = PXW'(out_pos_q);
  assign cnt_x = CXW'(out_count_q);

  assign status_o   = out_status_q;
  assign found_o    = out_found_q;
  assign position_o = pos_x[aste_pkg::POS_W-1:0];
  assign count_o    = cnt_x[aste_pkg::COUNT_W-1:0];
  assign is_empty_o = (out_count_q == '0);
  assign is_full_o  = (out_count_q == CW'(CAPACITY));

endmodule

[hw/rtl/aste_ctrl.sv]
// Controller of the table engine: command sequencing state machine and
// handshake control. Depends on aste_pkg.
module aste_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [aste_pkg::CMD_W-1:0]    command_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  input  aste_pkg::dp_stat_t            stat_i,
  output aste_pkg::ctl_cmd_t            cmd_o
);

  aste_pkg::state_e state_q, state_d;
  aste_pkg::cmd_e   op_q;
  logic             out_valid_q, out_valid_d;
  logic             out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      aste_pkg::S_IDLE: begin
        if (in_valid_i) state_d = aste_pkg::S_START;
      end
      aste_pkg::S_START: begin
        if (op_q == aste_pkg::CMD_APPEND || stat_i.empty) begin
          state_d = aste_pkg::S_PUBLISH;
        end else if (op_q == aste_pkg::CMD_SORT) begin
          state_d = aste_pkg::S_SORT_KEY;
        end else begin
          state_d = aste_pkg::S_SCAN;
        end
      end
      aste_pkg::S_SCAN: begin
        if (stat_i.hit) begin
          state_d = (op_q == aste_pkg::CMD_REMOVE) ? aste_pkg::S_SHIFT : aste_pkg::S_PUBLISH;
        end else if (stat_i.last) begin
          state_d = aste_pkg::S_PUBLISH;
        end
      end
      aste_pkg::S_SHIFT: begin
        if (stat_i.last) state_d = aste_pkg::S_PUBLISH;
      end
      aste_pkg::S_SORT_KEY: begin
        state_d = stat_i.sort_done ? aste_pkg::S_PUBLISH : aste_pkg::S_SORT_LOAD;
      end
      aste_pkg::S_SORT_LOAD: state_d = aste_pkg::S_SORT_CMP;
      aste_pkg::S_SORT_CMP: begin
        if (stat_i.j_zero || !stat_i.gt) state_d = aste_pkg::S_SORT_KEY;
      end
      aste_pkg::S_PUBLISH: begin
        if (out_free) state_d = aste_pkg::S_IDLE;
      end
      default: state_d = aste_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o            = '0;
    cmd_o.wr_sel     = aste_pkg::WR_VALUE;
    cmd_o.wa_sel     = aste_pkg::WA_COUNT;
    cmd_o.rd_sel     = aste_pkg::RD_ZERO;
    cmd_o.ptr_op     = aste_pkg::PTR_HOLD;
    cmd_o.res_status = aste_pkg::ST_OK;
    in_ready_o       = 1'b0;
    case (state_q)
      aste_pkg::S_IDLE: begin
        in_ready_o     = 1'b1;
        cmd_o.latch_in = in_valid_i;
      end
      aste_pkg::S_START: begin
        if (op_q == aste_pkg::CMD_APPEND) begin
          cmd_o.res_load = 1'b1;
          if (stat_i.full) begin
            cmd_o.res_status = aste_pkg::ST_FULL;
          end else begin
            cmd_o.mem_we  = 1'b1;
            cmd_o.cnt_inc = 1'b1;
          end
        end else if (stat_i.empty) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = aste_pkg::ST_EMPTY;
        end else if (op_q == aste_pkg::CMD_SORT) begin
          cmd_o.ptr_op = aste_pkg::PTR_ONE;
        end else begin
          cmd_o.ptr_op = aste_pkg::PTR_ZERO;
          cmd_o.rd_sel = aste_pkg::RD_ZERO;
        end
      end
      aste_pkg::S_SCAN: begin
        // The read of the following slot is always issued; it is dropped on a miss at the end.
        cmd_o.rd_sel = aste_pkg::RD_PTR1;
        if (stat_i.hit) begin
          cmd_o.res_load  = 1'b1;
          cmd_o.res_found = 1'b1;
        end else if (stat_i.last) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = aste_pkg::ST_MISS;
        end else begin
          cmd_o.ptr_op = aste_pkg::PTR_INC;
        end
      end
      aste_pkg::S_SHIFT: begin
        if (stat_i.last) begin
          cmd_o.cnt_dec = 1'b1;
        end else begin
          cmd_o.mem_we = 1'b1;
          cmd_o.wr_sel = aste_pkg::WR_RDATA;
          cmd_o.wa_sel = aste_pkg::WA_PTR;
          cmd_o.ptr_op = aste_pkg::PTR_INC;
          cmd_o.rd_sel = aste_pkg::RD_PTR2;
        end
      end
      aste_pkg::S_SORT_KEY: begin
        cmd_o.rd_sel = aste_pkg::RD_PTR;
        if (stat_i.sort_done) cmd_o.res_load = 1'b1;
      end
      aste_pkg::S_SORT_LOAD: begin
        cmd_o.key_load = 1'b1;
        cmd_o.j_load   = 1'b1;
        cmd_o.rd_sel   = aste_pkg::RD_PTRM1;
      end
      aste_pkg::S_SORT_CMP: begin
        cmd_o.mem_we = 1'b1;
        cmd_o.wa_sel = aste_pkg::WA_J;
        if (!stat_i.j_zero && stat_i.gt) begin
          cmd_o.wr_sel = aste_pkg::WR_RDATA;
          cmd_o.j_dec  = 1'b1;
          cmd_o.rd_sel = aste_pkg::RD_JM2;
        end else begin
          cmd_o.wr_sel = aste_pkg::WR_KEY;
          cmd_o.ptr_op = aste_pkg::PTR_INC;
        end
      end
      aste_pkg::S_PUBLISH: begin
        cmd_o.out_load = out_free;
      end
      default: begin
        cmd_o.latch_in = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= aste_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_o.latch_in) begin
      op_q <= aste_pkg::cmd_e'(command_i);
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[hw/rtl/array_set_table_engine_unit.sv]
// Table engine: append, search, remove and insertion sort on a slot memory.
// One transaction at a time; the next is accepted in the idle state entered as
// the result is registered, while that result still waits. Scans walk one slot
// per cycle. Reset empties the table and clears the controller; slot contents
// stay as is.
`include "assert_macros.svh"

module array_set_table_engine_unit #(
  parameter int unsigned CAPACITY = aste_pkg::CAPACITY_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [aste_pkg::CMD_W-1:0]          command_i,
  input  logic signed [aste_pkg::VALUE_W-1:0] value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [aste_pkg::STATUS_W-1:0]       status_o,
  output logic                                found_o,
  output logic [aste_pkg::POS_W-1:0]          position_o,
  output logic [aste_pkg::COUNT_W-1:0]        count_o,
  output logic                                is_empty_o,
  output logic                                is_full_o
);

  aste_pkg::ctl_cmd_t ctl_cmd;
  aste_pkg::dp_stat_t dp_stat;

  aste_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .command_i   (command_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (dp_stat),
    .cmd_o       (ctl_cmd)
  );

  aste_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (ctl_cmd),
    .stat_o     (dp_stat),
    .value_i    (value_i),
    .status_o   (status_o),
    .found_o    (found_o),
    .position_o (position_o),
    .count_o    (count_o),
    .is_empty_o (is_empty_o),
    .is_full_o  (is_full_o)
  );

  `ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  `ASSERT_IMPLY(a_found_is_ok, clk_i, rst_ni, out_valid_o && found_o, status_o == aste_pkg::ST_OK)
  `ASSERT_IMPLY(a_full_flag, clk_i, rst_ni, out_valid_o && status_o == aste_pkg::ST_FULL, is_full_o)
  `ASSERT_IMPLY(a_empty_flag, clk_i, rst_ni, out_valid_o && status_o == aste_pkg::ST_EMPTY, is_empty_o)

endmodule
